### src/mlpd_pkg.sv
// Shared types and constants for the motor link receive deframer.
// No dependencies; every other source file imports this package.
package mlpd_pkg;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 5;
    localparam int STEP_W  = 3;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENDER_A       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENDER_B       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_ID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESYNC_LIMIT   = 3'd4;

    // configuration reset values
    localparam logic [BYTE_W-1:0] RST_OWN_ADDRESS  = 8'd172;
    localparam logic [BYTE_W-1:0] RST_SENDER_A     = 8'd184;
    localparam logic [BYTE_W-1:0] RST_SENDER_B     = 8'd183;
    localparam logic [BYTE_W-1:0] RST_BROADCAST_ID = 8'd254;
    localparam logic [BYTE_W-1:0] RST_RESYNC_LIMIT = 8'd10;

    // unicast id always accepted in the id byte
    localparam logic [BYTE_W-1:0] UNICAST_ID = 8'd1;

    // parser step codes
    localparam logic [STEP_W-1:0] STEP_OWN_ADDR = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SENDER   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_ID       = 3'd2;
    localparam logic [STEP_W-1:0] STEP_COMMAND  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_LENGTH   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_PAYLOAD  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_CHECKSUM = 3'd6;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              chunk_end;
    } mlpd_in_t;

    typedef struct packed {
        logic               byte_kept;
        logic [INDEX_W-1:0] byte_index;
        logic               is_payload;
        logic               frame_done;
        logic               frame_good;
        logic [BYTE_W-1:0]  frame_sender;
        logic [BYTE_W-1:0]  frame_command;
        logic [BYTE_W-1:0]  frame_length;
        logic               resync;
    } mlpd_out_t;

endpackage

### src/mlpd_in_if.sv
// Valid/ready channel carrying received bytes into the deframer.
// Depends on mlpd_pkg for the payload type.
interface mlpd_in_if;
    import mlpd_pkg::*;

    logic     valid;
    logic     ready;
    mlpd_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/mlpd_out_if.sv
// Valid/ready channel carrying per-byte deframer results.
// Depends on mlpd_pkg for the payload type.
interface mlpd_out_if;
    import mlpd_pkg::*;

    logic      valid;
    logic      ready;
    mlpd_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/motor_link_packet_receive_deframer.sv
// Top level of the motor link receive deframer: parser, config registers
// and result register. Depends on mlpd_pkg, mlpd_in_if and mlpd_out_if.

// Receive deframer for a byte-serial motor link. Each transaction on in_ch
// carries one byte and a chunk_end flag and produces exactly one result
// transaction on out_ch, in order. A frame is own address, sender address
// (one of two), id (1 or broadcast), command, length, data bytes (at least
// one) and a checksum byte that makes the 8-bit sum of the frame zero. Every
// kept byte is reported with its position; the checksum byte reports
// frame_done and frame_good. Header mismatches raise an error count; when it
// equals resync_limit the parser clears, resync is flagged, and bytes up to
// and including the next chunk_end are ignored. Timing: one byte per clock.
// The parser update is a single combinational pass from the accepted byte
// and the parser state into the result register, so a new byte is taken in
// every cycle in which the result register is empty or being drained;
// the result is valid in the cycle after acceptance. Configuration
// writes (cfg_we, cfg_index, cfg_data) are expected only while idle.
module motor_link_packet_receive_deframer #(
    parameter int PAYLOAD_LIMIT = 24,
    parameter int FRAME_LIMIT   = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [mlpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mlpd_pkg::BYTE_W-1:0]    cfg_data,
    mlpd_in_if.sink                    in_ch,
    mlpd_out_if.source                 out_ch
);
    import mlpd_pkg::*;

    // frame position must be able to hold FRAME_LIMIT itself (saturation)
    localparam int POS_W = $clog2(FRAME_LIMIT + 1);
    localparam logic [POS_W-1:0]  POS_LIMIT = POS_W'(FRAME_LIMIT);
    localparam logic [BYTE_W-1:0] PAY_LIMIT = BYTE_W'(PAYLOAD_LIMIT);

    // configuration registers
    logic [BYTE_W-1:0] own_addr_reg;
    logic [BYTE_W-1:0] sender_a_reg;
    logic [BYTE_W-1:0] sender_b_reg;
    logic [BYTE_W-1:0] bcast_id_reg;
    logic [BYTE_W-1:0] resync_limit_reg;

    // parser state
    logic [STEP_W-1:0] step_reg,    step_next;
    logic [BYTE_W-1:0] sum_reg,     sum_next;
    logic [POS_W-1:0]  pos_reg,     pos_next;
    logic [BYTE_W-1:0] pay_cnt_reg, pay_cnt_next;
    logic [BYTE_W-1:0] exp_len_reg, exp_len_next;
    logic [BYTE_W-1:0] sender_reg,  sender_next;
    logic [BYTE_W-1:0] command_reg, command_next;
    logic [BYTE_W-1:0] err_cnt_reg, err_cnt_next;
    logic              skip_reg,    skip_next;
    logic              chunk_open_reg, chunk_open_next;

    // result register
    logic      out_valid_reg;
    mlpd_out_t out_reg;
    mlpd_out_t result;

    logic in_fire;
    logic [BYTE_W-1:0] b;
    logic store;

    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;
    assign b            = in_ch.data.rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg     <= RST_OWN_ADDRESS;
            sender_a_reg     <= RST_SENDER_A;
            sender_b_reg     <= RST_SENDER_B;
            bcast_id_reg     <= RST_BROADCAST_ID;
            resync_limit_reg <= RST_RESYNC_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_ADDRESS:  own_addr_reg     <= cfg_data;
                CFG_SENDER_A:     sender_a_reg     <= cfg_data;
                CFG_SENDER_B:     sender_b_reg     <= cfg_data;
                CFG_BROADCAST_ID: bcast_id_reg     <= cfg_data;
                CFG_RESYNC_LIMIT: resync_limit_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // one pass of the parser for the byte on in_ch
    always_comb
    begin
        step_next       = step_reg;
        sum_next        = sum_reg;
        pos_next        = pos_reg;
        pay_cnt_next    = pay_cnt_reg;
        exp_len_next    = exp_len_reg;
        sender_next     = sender_reg;
        command_next    = command_reg;
        err_cnt_next    = err_cnt_reg;
        skip_next       = skip_reg;
        chunk_open_next = chunk_open_reg;
        store           = 1'b0;
        result          = '0;

        // a chunk that opens on an overflowed frame is thrown away whole
        if (chunk_open_reg && (pos_reg >= POS_LIMIT))
        begin
            step_next = STEP_OWN_ADDR;
            pos_next  = '0;
            skip_next = 1'b1;
        end

        if (!skip_next)
        begin
            case (step_next)
                STEP_OWN_ADDR:
                begin
                    if (b == own_addr_reg)
                    begin
                        sender_next  = '0;
                        command_next = '0;
                        pos_next     = '0;
                        err_cnt_next = '0;
                        sum_next     = b;
                        store        = 1'b1;
                        step_next    = STEP_SENDER;
                    end
                    else
                    begin
                        pos_next     = '0;
                        err_cnt_next = err_cnt_reg + 8'd1;
                    end
                end
                STEP_SENDER:
                begin
                    if ((b == sender_a_reg) || (b == sender_b_reg))
                    begin
                        sum_next     = sum_reg + b;
                        sender_next  = b;
                        store        = 1'b1;
                        step_next    = STEP_ID;
                        err_cnt_next = '0;
                    end
                    else
                    begin
                        step_next    = STEP_OWN_ADDR;
                        pos_next     = '0;
                        err_cnt_next = err_cnt_reg + 8'd1;
                    end
                end
                STEP_ID:
                begin
                    if ((b == UNICAST_ID) || (b == bcast_id_reg))
                    begin
                        sum_next     = sum_reg + b;
                        store        = 1'b1;
                        step_next    = STEP_COMMAND;
                        err_cnt_next = '0;
                    end
                    else
                    begin
                        step_next    = STEP_OWN_ADDR;
                        pos_next     = '0;
                        err_cnt_next = err_cnt_reg + 8'd1;
                    end
                end
                STEP_COMMAND:
                begin
                    sum_next     = sum_reg + b;
                    command_next = b;
                    store        = 1'b1;
                    step_next    = STEP_LENGTH;
                end
                STEP_LENGTH:
                begin
                    exp_len_next = b;
                    pay_cnt_next = '0;
                    sum_next     = sum_reg + b;
                    store        = 1'b1;
                    step_next    = STEP_PAYLOAD;
                end
                STEP_PAYLOAD:
                begin
                    sum_next          = sum_reg + b;
                    store             = 1'b1;
                    result.is_payload = 1'b1;
                    pay_cnt_next      = pay_cnt_reg + 8'd1;
                    // zero length still takes one data byte
                    if (pay_cnt_next >= PAY_LIMIT)
                        step_next = STEP_OWN_ADDR;
                    else if (pay_cnt_next >= exp_len_reg)
                        step_next = STEP_CHECKSUM;
                end
                STEP_CHECKSUM:
                begin
                    sum_next          = sum_reg + b;
                    store             = 1'b1;
                    result.frame_done = 1'b1;
                    result.frame_good = (sum_next == '0);
                end
                default:
                begin
                    step_next = STEP_OWN_ADDR;
                end
            endcase

            result.frame_length = exp_len_next;

            if (store && (pos_next < POS_LIMIT))
            begin
                result.byte_kept  = 1'b1;
                result.byte_index = INDEX_W'(pos_next);
                pos_next          = pos_next + 1'b1;
            end
            else
            begin
                result.is_payload = 1'b0;
            end

            if (result.frame_done)
            begin
                if (result.frame_good)
                begin
                    pay_cnt_next = '0;
                    exp_len_next = '0;
                    pos_next     = '0;
                end
                step_next = STEP_OWN_ADDR;
            end

            if (err_cnt_next == resync_limit_reg)
            begin
                result.resync = 1'b1;
                err_cnt_next  = '0;
                step_next     = STEP_OWN_ADDR;
                sum_next      = '0;
                exp_len_next  = '0;
                pay_cnt_next  = '0;
                skip_next     = 1'b1;
            end
        end
        else
        begin
            result.frame_length = exp_len_reg;
        end

        // sender and command are reported before a resync clears them
        result.frame_sender  = sender_next;
        result.frame_command = command_next;
        if (result.resync)
        begin
            sender_next  = '0;
            command_next = '0;
        end

        if (in_ch.data.chunk_end)
        begin
            skip_next       = 1'b0;
            chunk_open_next = 1'b1;
        end
        else
        begin
            chunk_open_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_OWN_ADDR;
            sum_reg        <= '0;
            pos_reg        <= '0;
            pay_cnt_reg    <= '0;
            exp_len_reg    <= '0;
            sender_reg     <= '0;
            command_reg    <= '0;
            err_cnt_reg    <= '0;
            skip_reg       <= 1'b0;
            chunk_open_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                step_reg       <= step_next;
                sum_reg        <= sum_next;
                pos_reg        <= pos_next;
                pay_cnt_reg    <= pay_cnt_next;
                exp_len_reg    <= exp_len_next;
                sender_reg     <= sender_next;
                command_reg    <= command_next;
                err_cnt_reg    <= err_cnt_next;
                skip_reg       <= skip_next;
                chunk_open_reg <= chunk_open_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_reg <= result;
    end

    // checks

    // a good frame is only reported on its checksum byte
    a_good_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.frame_good |-> out_reg.frame_done)
        else $error("frame_good without frame_done");

    // a payload flag only comes with a kept byte
    a_payload_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.is_payload |-> out_reg.byte_kept)
        else $error("is_payload on a dropped byte");

    // a resync leaves the error count and the parser cleared
    a_resync_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && result.resync |=> (err_cnt_reg == '0) && (step_reg == STEP_OWN_ADDR)
            && (sender_reg == '0))
        else $error("resync did not clear parser state");

    // the frame position saturates at the frame limit
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LIMIT)
        else $error("frame position beyond limit");

endmodule

### tb/mlpd_checker.sv
`timescale 1ns / 100ps
// Result checker for the motor link receive deframer: tracks config writes,
// predicts one result per accepted byte and compares the result channel.
// Depends on mlpd_pkg, mlpd_in_if and mlpd_out_if.
module mlpd_checker #(
    parameter int PAYLOAD_LIMIT = 24,
    parameter int FRAME_LIMIT   = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mlpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mlpd_pkg::BYTE_W-1:0]    cfg_data,
    mlpd_in_if                             in_ch,
    mlpd_out_if                            out_ch,
    output int                             fail_count,
    output int                             pending
);
    import mlpd_pkg::*;

    localparam int MAX_REPORTS = 100;

    // configuration copy
    logic [BYTE_W-1:0] own_addr, sender_a, sender_b, bcast_id, resync_limit;

    // parser copy
    logic [STEP_W-1:0] step;
    logic [BYTE_W-1:0] byte_sum, data_count, declared_len;
    logic [BYTE_W-1:0] sender_byte, command_byte, error_count;
    int                frame_pos;
    logic              skipping, chunk_open;

    mlpd_out_t expected_results[$];

    // Advances the parser copy by one received byte and returns its result.
    function automatic mlpd_out_t deframe_byte(input logic [BYTE_W-1:0] rx,
                                               input logic last);
        mlpd_out_t          r;
        logic               store, keep, payload, done, good, rs;
        logic [INDEX_W-1:0] idx;
        logic [BYTE_W-1:0]  len_now;
        store   = 1'b0;
        keep    = 1'b0;
        payload = 1'b0;
        done    = 1'b0;
        good    = 1'b0;
        rs      = 1'b0;
        idx     = '0;

        // a chunk that opens on an overfull frame is thrown away whole
        if (chunk_open && frame_pos >= FRAME_LIMIT) begin
            step      = STEP_OWN_ADDR;
            frame_pos = 0;
            skipping  = 1'b1;
        end
        len_now = declared_len;

        if (!skipping) begin
            case (step)
                STEP_OWN_ADDR:
                begin
                    if (rx == own_addr) begin
                        sender_byte  = '0;
                        command_byte = '0;
                        frame_pos    = 0;
                        error_count  = '0;
                        byte_sum     = rx;
                        store        = 1'b1;
                        step         = STEP_SENDER;
                    end else begin
                        frame_pos   = 0;
                        error_count = error_count + 8'd1;
                    end
                end
                STEP_SENDER:
                begin
                    if (rx == sender_a || rx == sender_b) begin
                        byte_sum    = byte_sum + rx;
                        sender_byte = rx;
                        store       = 1'b1;
                        step        = STEP_ID;
                        error_count = '0;
                    end else begin
                        step        = STEP_OWN_ADDR;
                        frame_pos   = 0;
                        error_count = error_count + 8'd1;
                    end
                end
                STEP_ID:
                begin
                    if (rx == UNICAST_ID || rx == bcast_id) begin
                        byte_sum    = byte_sum + rx;
                        store       = 1'b1;
                        step        = STEP_COMMAND;
                        error_count = '0;
                    end else begin
                        step        = STEP_OWN_ADDR;
                        frame_pos   = 0;
                        error_count = error_count + 8'd1;
                    end
                end
                STEP_COMMAND:
                begin
                    byte_sum     = byte_sum + rx;
                    command_byte = rx;
                    store        = 1'b1;
                    step         = STEP_LENGTH;
                end
                STEP_LENGTH:
                begin
                    declared_len = rx;
                    data_count   = '0;
                    byte_sum     = byte_sum + rx;
                    store        = 1'b1;
                    step         = STEP_PAYLOAD;
                end
                STEP_PAYLOAD:
                begin
                    byte_sum   = byte_sum + rx;
                    store      = 1'b1;
                    payload    = 1'b1;
                    data_count = data_count + 8'd1;
                    if (data_count >= PAYLOAD_LIMIT)
                        step = STEP_OWN_ADDR;
                    else if (data_count >= declared_len)
                        step = STEP_CHECKSUM;
                end
                STEP_CHECKSUM:
                begin
                    byte_sum = byte_sum + rx;
                    store    = 1'b1;
                    done     = 1'b1;
                    good     = (byte_sum == '0);
                end
                default:
                begin
                    step = STEP_OWN_ADDR;
                end
            endcase
            len_now = declared_len;

            if (store) begin
                if (frame_pos < FRAME_LIMIT) begin
                    keep      = 1'b1;
                    idx       = frame_pos[INDEX_W-1:0];
                    frame_pos = frame_pos + 1;
                end else begin
                    payload = 1'b0;
                end
            end
            if (done) begin
                if (good) begin
                    data_count   = '0;
                    declared_len = '0;
                    frame_pos    = 0;
                end
                step = STEP_OWN_ADDR;
            end
            if (error_count == resync_limit) begin
                rs           = 1'b1;
                error_count  = '0;
                step         = STEP_OWN_ADDR;
                byte_sum     = '0;
                declared_len = '0;
                data_count   = '0;
                skipping     = 1'b1;
            end
        end

        r.byte_kept     = keep;
        r.byte_index    = keep ? idx : '0;
        r.is_payload    = keep && payload;
        r.frame_done    = done;
        r.frame_good    = good;
        r.frame_sender  = sender_byte;
        r.frame_command = command_byte;
        r.frame_length  = len_now;
        r.resync        = rs;

        // sender and command still show on the resync result, cleared after
        if (rs) begin
            sender_byte  = '0;
            command_byte = '0;
        end
        chunk_open = last;
        if (last)
            skipping = 1'b0;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        mlpd_out_t want;
        if (!rst_n) begin
            own_addr     = RST_OWN_ADDRESS;
            sender_a     = RST_SENDER_A;
            sender_b     = RST_SENDER_B;
            bcast_id     = RST_BROADCAST_ID;
            resync_limit = RST_RESYNC_LIMIT;
            step         = STEP_OWN_ADDR;
            byte_sum     = '0;
            data_count   = '0;
            declared_len = '0;
            sender_byte  = '0;
            command_byte = '0;
            error_count  = '0;
            frame_pos    = 0;
            skipping     = 1'b0;
            chunk_open   = 1'b1;
            fail_count   = 0;
            expected_results.delete();
        end else begin
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(deframe_byte(in_ch.data.rx_byte,
                                                        in_ch.data.chunk_end));
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t ns: unexpected result, expected none, actual %h",
                                 $time, out_ch.data);
                end else begin
                    want = expected_results.pop_front();
                    check_field("byte_kept", want.byte_kept, out_ch.data.byte_kept);
                    check_field("byte_index", want.byte_index, out_ch.data.byte_index);
                    check_field("is_payload", want.is_payload, out_ch.data.is_payload);
                    check_field("frame_done", want.frame_done, out_ch.data.frame_done);
                    check_field("frame_good", want.frame_good, out_ch.data.frame_good);
                    check_field("frame_sender", want.frame_sender,
                                out_ch.data.frame_sender);
                    check_field("frame_command", want.frame_command,
                                out_ch.data.frame_command);
                    check_field("frame_length", want.frame_length,
                                out_ch.data.frame_length);
                    check_field("resync", want.resync, out_ch.data.resync);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_OWN_ADDRESS:  own_addr     = cfg_data;
                    CFG_SENDER_A:     sender_a     = cfg_data;
                    CFG_SENDER_B:     sender_b     = cfg_data;
                    CFG_BROADCAST_ID: bcast_id     = cfg_data;
                    CFG_RESYNC_LIMIT: resync_limit = cfg_data;
                    default:          ;
                endcase
            end
        end
        pending = expected_results.size();
    end

endmodule

### tb/motor_link_packet_receive_deframer_test.sv
`timescale 1ns / 100ps
// Top of the deframer testbench: clock, reset, register writes, byte stimulus
// and the verdict. Depends on mlpd_pkg, the channel interfaces, the deframer
// and mlpd_checker, which does all prediction and comparison.
module motor_link_packet_receive_deframer_test;
    import mlpd_pkg::*;

    localparam int PAYLOAD_LIMIT  = 24;
    localparam int FRAME_LIMIT    = 32;
    // cycles with no transaction on either channel before giving up; far above
    // the longest receiver stall plus the pressure hold-off
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    // one byte in this many closes a chunk in the random part
    localparam int CHUNK_ODDS     = 12;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    int fail_count;
    int pending;

    // idle odds in percent; the sender's is used by the stimulus process,
    // the receiver's by the ready process
    int send_idle     = 22;
    int recv_idle     = 72;
    int hold_requests = 0;
    int items_sent    = 0;

    // copy of the register values, used only to build frames that match
    logic [BYTE_W-1:0] own_addr, sender_a, sender_b, bcast_id;

    // bytes waiting to go out as one burst
    logic [BYTE_W-1:0] burst[$];

    mlpd_in_if  in_ch();
    mlpd_out_if out_ch();

    always #1 clk = ~clk;

    motor_link_packet_receive_deframer #(
        .PAYLOAD_LIMIT(PAYLOAD_LIMIT),
        .FRAME_LIMIT  (FRAME_LIMIT)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    mlpd_checker #(
        .PAYLOAD_LIMIT(PAYLOAD_LIMIT),
        .FRAME_LIMIT  (FRAME_LIMIT)
    ) u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // Result side: random ready, plus a long hold-off whenever the stimulus
    // bumps hold_requests. The hold is counted here so the sender keeps
    // pushing bytes and the deframer has to back-pressure its input.
    initial
    begin : receiver
        int hold_seen;
        int hold_left;
        hold_seen    = 0;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // Watchdog: any stretch without a transaction on either channel ends the run.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no transaction for %0d cycles", $time, quiet);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Offers one byte, with random gaps first, and returns at the rising
    // edge that accepts it. valid stays high into the next call so back-to-back
    // bytes see no bubble.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {b, last};
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Sends the queued burst. chunk_odds of zero means no random chunk ends;
    // end_chunk marks the final byte as the last of its chunk.
    task automatic flush_burst(input int chunk_odds, input bit end_chunk);
        logic last;
        foreach (burst[i]) begin
            last = (chunk_odds > 0 && $urandom_range(1, chunk_odds) == 1)
                || (end_chunk && i == burst.size() - 1);
            send_byte(burst[i], last);
        end
        burst.delete();
    endtask

    // Register writes only happen with the deframer idle, so the copy kept
    // here changes in step with the one in the checker.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_OWN_ADDRESS:  own_addr     = val;
            CFG_SENDER_A:     sender_a     = val;
            CFG_SENDER_B:     sender_b     = val;
            CFG_BROADCAST_ID: bcast_id     = val;
            default:          ;
        endcase
    endtask

    task automatic write_all(input logic [BYTE_W-1:0] own, input logic [BYTE_W-1:0] snd_a,
                             input logic [BYTE_W-1:0] snd_b, input logic [BYTE_W-1:0] bcast,
                             input logic [BYTE_W-1:0] limit);
        write_reg(CFG_OWN_ADDRESS, own);
        write_reg(CFG_SENDER_A, snd_a);
        write_reg(CFG_SENDER_B, snd_b);
        write_reg(CFG_BROADCAST_ID, bcast);
        write_reg(CFG_RESYNC_LIMIT, limit);
    endtask

    // Stops offering and waits until every result has come back. Read at the
    // falling edge so the checker's count has settled.
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // Full frame: header, data bytes (one even for length zero, never more
    // than the payload cap) and a checksum, optionally spoiled by sum_err.
    // A declared length at or above the cap makes the deframer drop the frame; the
    // checksum byte then lands in the address hunt as a stray byte.
    function automatic void queue_frame(input logic [BYTE_W-1:0] snd,
                                        input logic [BYTE_W-1:0] id,
                                        input logic [BYTE_W-1:0] cmd,
                                        input logic [BYTE_W-1:0] len,
                                        input logic [BYTE_W-1:0] sum_err);
        int                first;
        int                n;
        logic [BYTE_W-1:0] total;
        first = burst.size();
        burst.push_back(own_addr);
        burst.push_back(snd);
        burst.push_back(id);
        burst.push_back(cmd);
        burst.push_back(len);
        n = (len == 0) ? 1 : int'(len);
        if (n > PAYLOAD_LIMIT)
            n = PAYLOAD_LIMIT;
        repeat (n) burst.push_back(BYTE_W'($urandom_range(0, 255)));
        total = '0;
        for (int i = first; i < burst.size(); i++)
            total = total + burst[i];
        burst.push_back((8'd0 - total) ^ sum_err);
    endfunction

    // Good start byte followed by a bad sender byte or a bad id byte.
    function automatic void queue_header_break();
        logic [BYTE_W-1:0] bad;
        burst.push_back(own_addr);
        if ($urandom_range(0, 1)) begin
            do bad = BYTE_W'($urandom_range(0, 255));
            while (bad == sender_a || bad == sender_b);
            burst.push_back(bad);
        end else begin
            burst.push_back($urandom_range(0, 1) ? sender_a : sender_b);
            do bad = BYTE_W'($urandom_range(0, 255));
            while (bad == UNICAST_ID || bad == bcast_id);
            burst.push_back(bad);
        end
    endfunction

    // Line noise; with avoid_own set no byte can open a frame, so the error
    // count only climbs.
    function automatic void queue_noise(input int n, input bit avoid_own);
        logic [BYTE_W-1:0] b;
        repeat (n) begin
            b = BYTE_W'($urandom_range(0, 255));
            if (avoid_own && b == own_addr)
                b = b ^ 8'h01;
            burst.push_back(b);
        end
    endfunction

    // Well-formed frames with random content, just under half of the items, so the
    // payload and checksum steps see real traffic; the rest are spoiled checksums,
    // over-long frames, broken headers and noise.
    task automatic run_random(input int count);
        int                stop_at;
        int                kind;
        logic [BYTE_W-1:0] len;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            // short frames dominate, the full payload range shows up now and then
            if ($urandom_range(0, 3) == 0)
                len = BYTE_W'($urandom_range(0, PAYLOAD_LIMIT - 1));
            else
                len = BYTE_W'($urandom_range(0, 4));
            if (kind < 48)
                queue_frame($urandom_range(0, 1) ? sender_a : sender_b,
                            $urandom_range(0, 1) ? UNICAST_ID : bcast_id,
                            BYTE_W'($urandom_range(0, 255)), len, 8'h00);
            else if (kind < 62)
                queue_frame($urandom_range(0, 1) ? sender_a : sender_b,
                            $urandom_range(0, 1) ? UNICAST_ID : bcast_id,
                            BYTE_W'($urandom_range(0, 255)), len,
                            BYTE_W'($urandom_range(1, 255)));
            else if (kind < 70)
                queue_frame($urandom_range(0, 1) ? sender_a : sender_b,
                            $urandom_range(0, 1) ? UNICAST_ID : bcast_id,
                            BYTE_W'($urandom_range(0, 255)),
                            BYTE_W'($urandom_range(PAYLOAD_LIMIT, 255)), 8'h00);
            else if (kind < 80)
                queue_header_break();
            else
                queue_noise($urandom_range(1, 6), 1'b0);
            flush_burst(CHUNK_ODDS, 1'b0);
        end
    endtask

    initial
    begin : stimulus
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_OWN_ADDRESS;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        own_addr     = RST_OWN_ADDRESS;
        sender_a     = RST_SENDER_A;
        sender_b     = RST_SENDER_B;
        bcast_id     = RST_BROADCAST_ID;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part, reset register values ----
        // shortest legal frame: length zero still carries one data byte;
        // its checksum byte also closes the chunk
        queue_frame(sender_a, UNICAST_ID, 8'h00, 8'h00, 8'h00);
        flush_burst(0, 1'b1);
        // broadcast id from the second sender, checksum off by one
        queue_frame(sender_b, bcast_id, 8'hFF, 8'h01, 8'h01);
        flush_burst(0, 1'b0);
        // header mismatches: all-zero sender byte, then all-ones id byte
        burst = '{own_addr, 8'h00, own_addr, sender_a, 8'hFF};
        flush_burst(0, 1'b0);
        // stray bytes at both extremes, the second one closing the chunk
        burst = '{8'hFF, 8'h00};
        flush_burst(0, 1'b1);

        // ---- random part, reset register values ----
        run_random(380);
        drain();

        // ---- low extremes, resync on the first error; sender idles more ----
        write_all(8'h00, 8'hFF, 8'h00, 8'hFF, 8'd1);
        send_idle = 72;
        recv_idle = 22;
        run_random(380);
        drain();

        // ---- high extremes with the slowest resync, no idling ----
        write_all(8'hFF, 8'h01, 8'hFE, 8'h00, 8'd255);
        send_idle = 0;
        recv_idle = 0;
        // start the long hold-off on a rising edge, clear of the ready update
        @(posedge clk);
        hold_requests++;
        // enough unbroken noise to run the error count all the way to the limit
        queue_noise(300, 1'b1);
        flush_burst(CHUNK_ODDS, 1'b0);
        run_random(250);
        drain();

        // ---- random registers, small resync limit ----
        write_all(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                  BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                  BYTE_W'($urandom_range(2, 12)));
        run_random(400);
        drain();

        // spare cycles after the last drain catch any stray result
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
src/mlpd_pkg.sv
src/mlpd_in_if.sv
src/mlpd_out_if.sv
src/motor_link_packet_receive_deframer.sv
tb/mlpd_checker.sv
tb/motor_link_packet_receive_deframer_test.sv
